[src/rc4sm_pkg.sv]
// Shared constants and types for the RC4 / SplitMix64 keystream generator.
package rc4sm_pkg;

    localparam int PERM_DEPTH = 256;
    localparam int PERM_AW    = $clog2(PERM_DEPTH);

    localparam logic [63:0] GOLDEN_STEP = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [63:0] MIX_MUL_A   = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [63:0] MIX_MUL_B   = 64'h94d0_49bb_1331_11eb;

    localparam logic OP_KEY = 1'b0;
    localparam logic OP_GEN = 1'b1;

    typedef struct packed {
        logic               clear;
        logic               rd_en;
        logic [PERM_AW-1:0] rd_addr;
        logic               wr_en;
        logic [PERM_AW-1:0] wr_addr;
        logic [7:0]         wr_data;
    } perm_req_t;

endpackage

[src/rc4sm_perm_ram.sv]
// Permutation memory: synchronous RAM with per-entry valid bits; invalid entries read as their index.
module rc4sm_perm_ram
    import rc4sm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  perm_req_t  req,
    output logic [7:0] rd_data
);

    logic [7:0]            mem [PERM_DEPTH];
    logic [PERM_DEPTH-1:0] valid_reg;
    logic [7:0]            rd_q_reg;
    logic [PERM_AW-1:0]    rd_addr_reg;
    logic                  rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_q_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_addr_reg  <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.clear)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_addr_reg  <= req.rd_addr;
                rd_valid_reg <= req.clear ? 1'b0 : valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_q_reg : 8'(rd_addr_reg);

endmodule

[src/rc4sm_mixer.sv]
// SplitMix64 output function computed sequentially, both multiply rounds on one shared 32x32 multiplier.
module rc4sm_mixer
    import rc4sm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] counter,
    output logic        ready,
    output logic [63:0] word
);

    typedef enum logic [5:0] {
        MX_IDLE = 6'b000001,
        MX_LOAD = 6'b000010,
        MX_M0   = 6'b000100,
        MX_M1   = 6'b001000,
        MX_M2   = 6'b010000,
        MX_M3   = 6'b100000
    } mx_state_t;

    mx_state_t   state_reg;
    logic        round_reg;
    logic [63:0] a_reg;
    logic [63:0] acc_reg;
    logic [63:0] prod_reg;
    logic [63:0] word_reg;

    logic [63:0] sum;
    logic [63:0] k;
    logic [31:0] mult_a;
    logic [31:0] mult_b;
    logic [63:0] prod_comb;
    logic [63:0] fin;

    assign sum = counter + GOLDEN_STEP;
    assign k   = round_reg ? MIX_MUL_B : MIX_MUL_A;

    always_comb
    begin
        mult_a = a_reg[31:0];
        mult_b = k[31:0];
        case (state_reg)
            MX_M1:
            begin
                mult_b = k[63:32];
            end
            MX_M2:
            begin
                mult_a = a_reg[63:32];
            end
            default:
            begin
                mult_a = a_reg[31:0];
                mult_b = k[31:0];
            end
        endcase
    end

    assign prod_comb = mult_a * mult_b;
    assign fin       = {acc_reg[63:32] + prod_reg[31:0], acc_reg[31:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MX_LOAD;
            round_reg <= 1'b0;
            a_reg     <= '0;
            acc_reg   <= '0;
            prod_reg  <= '0;
            word_reg  <= '0;
        end
        else
        begin
            prod_reg <= prod_comb;
            if (start)
            begin
                state_reg <= MX_LOAD;
            end
            else
            begin
                case (state_reg)
                    MX_LOAD:
                    begin
                        a_reg     <= sum ^ (sum >> 30);
                        round_reg <= 1'b0;
                        state_reg <= MX_M0;
                    end
                    MX_M0:
                    begin
                        state_reg <= MX_M1;
                    end
                    MX_M1:
                    begin
                        acc_reg   <= prod_reg;
                        state_reg <= MX_M2;
                    end
                    MX_M2:
                    begin
                        acc_reg[63:32] <= acc_reg[63:32] + prod_reg[31:0];
                        state_reg      <= MX_M3;
                    end
                    MX_M3:
                    begin
                        if (!round_reg)
                        begin
                            a_reg     <= fin ^ (fin >> 27);
                            round_reg <= 1'b1;
                            state_reg <= MX_M0;
                        end
                        else
                        begin
                            word_reg  <= fin ^ (fin >> 31);
                            state_reg <= MX_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= MX_IDLE;
                    end
                endcase
            end
        end
    end

    assign ready = (state_reg == MX_IDLE);
    assign word  = word_reg;

endmodule

[src/rc4_splitmix_keystream.sv]
// Top level: RC4 permutation sequencer with SplitMix64 byte combining.
// Every item, key byte or generate, runs through IDLE, FETCH, SWAP and FINISH: the
// transfer in IDLE issues the first permutation read, FETCH the second read, SWAP the
// first swap write and, for a generate, the output lookup, and FINISH the second swap
// write, all through the one read port and one write port of the permutation memory.
// The next item is accepted in the cycle after the last write. A generate item that
// needs a fresh SplitMix64 word (every eighth byte) waits until the mixer is done; the
// mixer restarts after reset, after a refresh and when a key schedule completes, so only
// the first byte after reset or after a schedule can be delayed. A result held in the
// output register stalls only the next generate item, in its last cycle. The permutation
// returns to identity at once, through valid bits, on reset and on the first key byte.
module rc4_splitmix_keystream
    import rc4sm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [7:0]  key_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  stream_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_FETCH  = 4'b0010,
        ST_SWAP   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic               op_reg, op_next;
    logic [7:0]         key_reg, key_next;
    logic [PERM_AW-1:0] addr_a_reg, addr_a_next;
    logic [7:0]         sa_reg, sa_next;
    logic [7:0]         sb_reg, sb_next;
    logic [PERM_AW-1:0] t_reg, t_next;
    logic [PERM_AW-1:0] i_reg, i_next;
    logic [PERM_AW-1:0] j_reg, j_next;
    logic [PERM_AW-1:0] kpos_reg, kpos_next;
    logic [63:0]        seed_reg, seed_next;
    logic [63:0]        counter_reg, counter_next;
    logic [63:0]        word_reg, word_next;
    logic [2:0]         bpos_reg, bpos_next;
    logic               add_reg, add_next;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_byte_reg, out_byte_next;

    perm_req_t          perm_req;
    logic [7:0]         perm_rd;
    logic               mix_start;
    logic               mix_ready;
    logic [63:0]        mix_word;

    logic               in_xfer;
    logic               refresh;
    logic               gen_go;
    logic [63:0]        cur_word;
    logic [7:0]         mix_byte;
    logic [7:0]         rc4_byte;

    rc4sm_perm_ram u_perm (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (perm_req),
        .rd_data (perm_rd)
    );

    rc4sm_mixer u_mixer (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mix_start),
        .counter (counter_reg),
        .ready   (mix_ready),
        .word    (mix_word)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign refresh  = (bpos_reg == 3'd0);
    assign cur_word = refresh ? mix_word : word_reg;
    assign mix_byte = 8'(cur_word >> {~bpos_reg, 3'b000});
    assign rc4_byte = (t_reg == j_reg)      ? sa_reg :
                      (t_reg == addr_a_reg) ? sb_reg : perm_rd;
    assign gen_go   = (state_reg == ST_FINISH) && (op_reg == OP_GEN)
                      && !(refresh && !mix_ready) && !(out_valid_reg && !out_ready);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        addr_a_next    = addr_a_reg;
        sa_next        = sa_reg;
        sb_next        = sb_reg;
        t_next         = t_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        kpos_next      = kpos_reg;
        seed_next      = (cfg_valid && cfg_ready) ? cfg_data : seed_reg;
        counter_next   = counter_reg;
        word_next      = word_reg;
        bpos_next      = bpos_reg;
        add_next       = add_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        mix_start      = 1'b0;
        perm_req       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    op_next          = opcode;
                    key_next         = key_byte;
                    perm_req.rd_en   = 1'b1;
                    if (opcode == OP_GEN)
                    begin
                        i_next           = i_reg + 1'b1;
                        perm_req.rd_addr = i_reg + 1'b1;
                    end
                    else
                    begin
                        perm_req.rd_addr = kpos_reg;
                        if (kpos_reg == '0)
                        begin
                            perm_req.clear = 1'b1;
                            j_next         = '0;
                        end
                    end
                    addr_a_next = perm_req.rd_addr;
                    state_next  = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                sa_next = perm_rd;
                j_next  = j_reg + perm_rd + ((op_reg == OP_KEY) ? key_reg : 8'd0);
                perm_req.rd_en   = 1'b1;
                perm_req.rd_addr = j_next;
                state_next       = ST_SWAP;
            end
            ST_SWAP:
            begin
                sb_next          = perm_rd;
                perm_req.wr_en   = 1'b1;
                perm_req.wr_addr = addr_a_reg;
                perm_req.wr_data = perm_rd;
                if (op_reg == OP_GEN)
                begin
                    t_next           = sa_reg + perm_rd;
                    perm_req.rd_en   = 1'b1;
                    perm_req.rd_addr = t_next;
                end
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                perm_req.wr_en   = 1'b1;
                perm_req.wr_addr = j_reg;
                perm_req.wr_data = sa_reg;
                if (op_reg == OP_KEY)
                begin
                    kpos_next = kpos_reg + 1'b1;
                    if (kpos_reg == '1)
                    begin
                        i_next       = '0;
                        j_next       = '0;
                        counter_next = seed_reg;
                        bpos_next    = 3'd0;
                        add_next     = 1'b0;
                        mix_start    = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
                else if (gen_go)
                begin
                    if (refresh)
                    begin
                        word_next    = mix_word;
                        counter_next = counter_reg + GOLDEN_STEP;
                        mix_start    = 1'b1;
                    end
                    out_byte_next  = add_reg ? (mix_byte + rc4_byte) : (mix_byte ^ rc4_byte);
                    out_valid_next = 1'b1;
                    bpos_next      = bpos_reg + 1'b1;
                    add_next       = !add_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_KEY;
            key_reg       <= '0;
            addr_a_reg    <= '0;
            sa_reg        <= '0;
            sb_reg        <= '0;
            t_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            kpos_reg      <= '0;
            seed_reg      <= '0;
            counter_reg   <= '0;
            word_reg      <= '0;
            bpos_reg      <= '0;
            add_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            key_reg       <= key_next;
            addr_a_reg    <= addr_a_next;
            sa_reg        <= sa_next;
            sb_reg        <= sb_next;
            t_reg         <= t_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            kpos_reg      <= kpos_next;
            seed_reg      <= seed_next;
            counter_reg   <= counter_next;
            word_reg      <= word_next;
            bpos_reg      <= bpos_next;
            add_reg       <= add_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign stream_byte = out_byte_reg;

`ifndef SYNTHESIS
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !perm_req.wr_en)
        else $error("permutation write while idle");

    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_FINISH && op_reg == OP_GEN))
        else $error("result appeared outside a generate finish");

    a_schedule_restarts_mixer: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && op_reg == OP_KEY && kpos_reg == '1) |=> !mix_ready)
        else $error("mixer not restarted at schedule completion");
`endif

endmodule

[sim/testbench.sv]
// Self-checking testbench for the RC4 / SplitMix64 keystream generator.
`timescale 1ns / 100ps

module testbench
    import rc4sm_pkg::*;
();

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        opcode;
    logic [7:0]  key_byte;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  stream_byte;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [63:0] cfg_data;

    rc4_splitmix_keystream u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .key_byte    (key_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .stream_byte (stream_byte),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // shadow of the generator state
    logic [7:0]  sbox [PERM_DEPTH];
    logic [7:0]  ks_i;
    logic [7:0]  ks_j;
    logic [7:0]  sched_pos;
    logic [63:0] sm_state;
    logic [63:0] sm_word;
    logic [2:0]  word_byte;
    logic        add_turn;
    logic [63:0] seed_shadow;

    logic [7:0]  pending_bytes [$];
    logic [7:0]  want;
    int          errors;
    int          bytes_checked;
    int          keys_sent;
    int          gens_sent;
    int          schedules_done;
    int          seeds_written;
    int          burst_left;
    bit          hold_req;
    bit          hold_done;

    typedef struct packed {
        logic       op;
        logic [7:0] kb;
        logic       typed;
        logic [7:0] want;
    } stim_row_t;

    localparam int N_DIRECTED = 18;

    // typed bytes: identity permutation, SplitMix64 word from a zero counter
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{OP_GEN, 8'h00, 1'b1, 8'he0},
        '{OP_GEN, 8'hff, 1'b1, 8'h25},
        '{OP_GEN, 8'h5a, 1'b0, 8'h00},
        '{OP_KEY, 8'h00, 1'b0, 8'h00},
        '{OP_KEY, 8'hff, 1'b0, 8'h00},
        '{OP_KEY, 8'h80, 1'b0, 8'h00},
        '{OP_KEY, 8'h01, 1'b0, 8'h00},
        '{OP_GEN, 8'h00, 1'b0, 8'h00},
        '{OP_GEN, 8'h00, 1'b0, 8'h00},
        '{OP_KEY, 8'h7f, 1'b0, 8'h00},
        '{OP_KEY, 8'haa, 1'b0, 8'h00},
        '{OP_KEY, 8'h55, 1'b0, 8'h00},
        '{OP_GEN, 8'h00, 1'b0, 8'h00},
        '{OP_KEY, 8'hfe, 1'b0, 8'h00},
        '{OP_GEN, 8'h00, 1'b0, 8'h00},
        '{OP_GEN, 8'h00, 1'b0, 8'h00},
        '{OP_GEN, 8'h00, 1'b0, 8'h00},
        '{OP_GEN, 8'h00, 1'b0, 8'h00}
    };

    function automatic void clear_shadow();
        int k;
        for (k = 0; k < PERM_DEPTH; k++)
            sbox[k] = k[7:0];
        ks_i        = 8'd0;
        ks_j        = 8'd0;
        sched_pos   = 8'd0;
        sm_state    = 64'd0;
        sm_word     = 64'd0;
        word_byte   = 3'd0;
        add_turn    = 1'b0;
        seed_shadow = 64'd0;
    endfunction

    function automatic void absorb_key_byte(input logic [7:0] kb);
        int         k;
        logic [7:0] tmp;
        if (sched_pos == 8'd0)
        begin
            for (k = 0; k < PERM_DEPTH; k++)
                sbox[k] = k[7:0];
            ks_j = 8'd0;
        end
        ks_j = ks_j + sbox[sched_pos] + kb;
        tmp = sbox[sched_pos];
        sbox[sched_pos] = sbox[ks_j];
        sbox[ks_j] = tmp;
        sched_pos = sched_pos + 8'd1;
        if (sched_pos == 8'd0)
        begin
            ks_i      = 8'd0;
            ks_j      = 8'd0;
            sm_state  = seed_shadow;
            word_byte = 3'd0;
            add_turn  = 1'b0;
            schedules_done++;
        end
    endfunction

    function automatic logic [7:0] next_stream_byte();
        logic [7:0]  tmp;
        logic [7:0]  t;
        logic [7:0]  rc4_byte;
        logic [7:0]  mix_byte;
        logic [63:0] z;
        ks_i = ks_i + 8'd1;
        ks_j = ks_j + sbox[ks_i];
        tmp = sbox[ks_i];
        sbox[ks_i] = sbox[ks_j];
        sbox[ks_j] = tmp;
        t = sbox[ks_i] + sbox[ks_j];
        rc4_byte = sbox[t];
        if (word_byte == 3'd0)
        begin
            sm_state = sm_state + GOLDEN_STEP;
            z = sm_state;
            z = (z ^ (z >> 30)) * MIX_MUL_A;
            z = (z ^ (z >> 27)) * MIX_MUL_B;
            sm_word = z ^ (z >> 31);
        end
        mix_byte = sm_word[8 * (7 - int'(word_byte)) +: 8];
        word_byte = word_byte + 3'd1;
        if (!add_turn)
        begin
            add_turn = 1'b1;
            return mix_byte ^ rc4_byte;
        end
        add_turn = 1'b0;
        return mix_byte + rc4_byte;
    endfunction

    // offer one item in bursts with random gaps; returns at the accepting edge
    task automatic send_item(input logic op, input logic [7:0] kb);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        opcode   <= op;
        key_byte <= kb;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic issue(input logic op, input logic [7:0] kb,
                         input logic typed, input logic [7:0] typed_byte);
        logic [7:0] b;
        send_item(op, kb);
        if (op == OP_GEN)
        begin
            b = next_stream_byte();
            pending_bytes.push_back(typed ? typed_byte : b);
            gens_sent++;
        end
        else
        begin
            absorb_key_byte(kb);
            keys_sent++;
        end
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge clk);
        repeat (24) @(posedge clk);
    endtask

    task automatic write_seed(input logic [63:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        seed_shadow = value;
        seeds_written++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int budget, input bit with_hold);
        int sent;
        int n;
        int k;
        sent = 0;
        while (sent < budget)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                // finish the schedule, an odd output byte mixed in
                do
                begin
                    if ($urandom_range(0, 31) == 0)
                        issue(OP_GEN, 8'($urandom_range(0, 255)), 1'b0, 8'h00);
                    else
                        issue(OP_KEY, 8'($urandom_range(0, 255)), 1'b0, 8'h00);
                    sent++;
                end
                while (sched_pos != 8'd0);
                if (with_hold)
                    hold_req = 1'b1;
                n = $urandom_range(16, 90);
                for (k = 0; k < n; k++)
                    issue(OP_GEN, 8'($urandom_range(0, 255)), 1'b0, 8'h00);
                sent += n;
            end
            else
            begin
                n = $urandom_range(1, 24);
                for (k = 0; k < n; k++)
                    issue(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          1'b0, 8'h00);
                sent += n;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_bytes.size() == 0)
            begin
                $display("%0t: stream_byte %02h with nothing expected", $time, stream_byte);
                errors++;
            end
            else
            begin
                want = pending_bytes.pop_front();
                bytes_checked++;
                if (stream_byte !== want)
                begin
                    $display("%0t: stream_byte expected %02h got %02h",
                             $time, want, stream_byte);
                    errors++;
                end
            end
        end
    end

    initial
    begin : rx_side
        int seg_left;
        int mode;
        int tick;
        out_ready = 1'b0;
        seg_left  = 0;
        mode      = 0;
        tick      = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                // long stall so the pipe backs up into the input
                out_ready <= 1'b0;
                repeat (400) @(negedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_left = $urandom_range(20, 200);
                    mode     = $urandom_range(0, 3);
                end
                seg_left--;
                tick++;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= (tick % 4 == 0);
                    default: out_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial
    begin
        #5000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        logic [63:0] seeds [6];
        int          r;
        int          ph;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        opcode    = OP_KEY;
        key_byte  = 8'd0;
        cfg_valid = 1'b0;
        cfg_data  = 64'd0;
        errors         = 0;
        bytes_checked  = 0;
        keys_sent      = 0;
        gens_sent      = 0;
        schedules_done = 0;
        seeds_written  = 0;
        burst_left     = 0;
        hold_req       = 1'b0;
        hold_done      = 1'b0;
        clear_shadow();

        seeds[0] = 64'hffff_ffff_ffff_ffff;    // counter wraps on first word
        seeds[1] = 64'd0;
        seeds[2] = 64'h61c8_8646_80b5_83eb;    // first advance lands on zero
        seeds[3] = {$urandom, $urandom};
        seeds[4] = {$urandom, $urandom};
        seeds[5] = 64'h8000_0000_0000_0000;

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        write_seed(seeds[0]);
        for (r = 0; r < N_DIRECTED; r++)
            issue(DIRECTED[r].op, DIRECTED[r].kb, DIRECTED[r].typed, DIRECTED[r].want);

        for (ph = 0; ph < 6; ph++)
        begin
            if (ph > 0)
            begin
                settle();
                write_seed(seeds[ph]);
            end
            run_phase(250, ph == 2);
        end
        settle();

        $display("Sent %0d key bytes and %0d generate requests; %0d output bytes checked.",
                 keys_sent, gens_sent, bytes_checked);
        $display("Completed %0d key schedules over %0d seed values, with one long output stall.",
                 schedules_done, seeds_written);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
